FILE: src/two_track_animation_clock_sync_unit_defines.svh
// Assertion macros shared by the animation clock sync RTL.
`ifndef TWO_TRACK_ANIMATION_CLOCK_SYNC_UNIT_DEFINES_SVH
`define TWO_TRACK_ANIMATION_CLOCK_SYNC_UNIT_DEFINES_SVH

// Implication checked every clock, off during reset.
`define TTACS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Plain invariant checked every clock, off during reset.
`define TTACS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("invariant failed");

`endif

FILE: src/ttacs_pkg.sv
// Shared types and constants of the animation clock sync unit.
package ttacs_pkg;

  localparam int unsigned TimeW     = 24;
  localparam int unsigned RateW     = 8;
  localparam int unsigned WeightW   = 16;
  localparam int unsigned FrameW    = 16;
  localparam int unsigned FlagsW    = 2;

  localparam logic [TimeW-1:0] TimeStepReset = 24'd1092;
  localparam logic [TimeW-1:0] TimeMax       = 24'hFF_FFFF;

  // Flag bit positions.
  localparam int unsigned FlagPaused = 0;
  localparam int unsigned FlagLoop   = 1;

  // Divider: quotient bits kept before saturation, bits resolved per stage.
  localparam int unsigned DivQBits        = 26;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages       = DivQBits / DivBitsPerStage;

  // Register address map (byte address bit 2 selects the word).
  localparam logic RegTimeStep = 1'b0;

  localparam int unsigned InDataW  = 200;
  localparam int unsigned OutDataW = 88;

  typedef struct packed {
    logic [TimeW-1:0] nt0;
    logic [TimeW-1:0] nt1;
    logic [RateW-1:0] rt0;
    logic [RateW-1:0] rt1;
    logic [1:0]       act;
    logic             main;
    logic             place_en;
    logic             use_div;
    logic [TimeW-1:0] ds;
  } meta_t;

endpackage

FILE: src/two_track_animation_clock_sync_unit.sv
// Top level: two-track animation clock step with main-track placement.
//
//  channel | dir | handshake           | payload
//  s_*     | in  | s_tvalid/s_tready   | s_tdata: both tracks' time/span/rate/weight/flags
//  m_*     | out | m_tvalid/m_tready   | m_tdata: new times, frames, main track, mask
//  apb     | in  | psel/penable/pready | time_step at byte address 0
//
// One beat per cycle while the output beat is not held; the stages are advance, span diffs,
// 25x25 multiply, magnitude, 13 radix-4 divider stages, placement and frames.
// The restoring divider, two quotient bits per stage, sets the depth.
// A single enable stalls all stages together when the output beat is held.
// Reset clears valid bits and loads time_step with its default.
`include "two_track_animation_clock_sync_unit_defines.svh"
module two_track_animation_clock_sync_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  // lsb up: time_a, start_a, end_a, rate_a, weight_a, flags_a,
  //         time_b, start_b, end_b, rate_b, weight_b, flags_b, zero pad
  input  logic [ttacs_pkg::InDataW-1:0] s_tdata_i,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  // lsb up: new_time_a, frame_a, new_time_b, frame_b, main_track,
  //         updated_mask, zero pad
  output logic [ttacs_pkg::OutDataW-1:0] m_tdata_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned TW = ttacs_pkg::TimeW;
  localparam int unsigned NS = ttacs_pkg::DivStages;
  localparam int unsigned QB = ttacs_pkg::DivQBits;

  // ---------------- configuration ----------------
  logic [TW-1:0] step_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ttacs_pkg::TimeStepReset;
    end else if (psel && penable && pwrite && (paddr[2] == ttacs_pkg::RegTimeStep)) begin
      step_q <= pwdata[TW-1:0];
    end
  end
  assign prdata = (paddr[2] == ttacs_pkg::RegTimeStep) ? {8'd0, step_q} : 32'd0;

  // ---------------- pipeline enable ----------------
  logic out_valid_q;
  logic en;
  assign en         = !out_valid_q || m_tready_i;
  assign s_tready_o = en;

  // ---------------- stage 1: advance, pick main ----------------
  logic [TW-1:0] tm [2];
  logic [TW-1:0] st [2];
  logic [TW-1:0] ed [2];
  logic [7:0]    rt [2];
  logic [15:0]   wt [2];
  logic [1:0]    fl [2];
  logic [TW-1:0] nt [2];
  logic [1:0]    act;

  assign tm[0] = s_tdata_i[23:0];    assign st[0] = s_tdata_i[47:24];
  assign ed[0] = s_tdata_i[71:48];   assign rt[0] = s_tdata_i[79:72];
  assign wt[0] = s_tdata_i[95:80];   assign fl[0] = s_tdata_i[97:96];
  assign tm[1] = s_tdata_i[121:98];  assign st[1] = s_tdata_i[145:122];
  assign ed[1] = s_tdata_i[169:146]; assign rt[1] = s_tdata_i[177:170];
  assign wt[1] = s_tdata_i[193:178]; assign fl[1] = s_tdata_i[195:194];

  for (genvar k = 0; k < 2; k++) begin : g_adv
    logic [TW:0]   sum;
    logic [TW-1:0] adv;
    always_comb begin
      sum = {1'b0, tm[k]} + {1'b0, step_q};
      if (sum >= {1'b0, ed[k]}) begin
        adv = fl[k][ttacs_pkg::FlagLoop] ? st[k] : ed[k];
      end else begin
        adv = sum[TW-1:0];
      end
      act[k] = !fl[k][ttacs_pkg::FlagPaused] && (wt[k] != '0);
      nt[k]  = act[k] ? adv : tm[k];
    end
  end

  logic mainx, other, src_sel, src_ok;
  assign mainx   = wt[1] > wt[0];
  assign other   = ~mainx;
  assign src_sel = act[mainx] ? mainx : 1'b0;
  assign src_ok  = act[mainx] || (mainx && act[0]);

  ttacs_pkg::meta_t s1_meta_q;
  logic s1_valid_q, s1_src_ok_q;
  logic [TW-1:0] s1_sts_q, s1_ss_q, s1_se_q, s1_de_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_tvalid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_meta_q.nt0      <= nt[0];
      s1_meta_q.nt1      <= nt[1];
      s1_meta_q.rt0      <= rt[0];
      s1_meta_q.rt1      <= rt[1];
      s1_meta_q.act      <= act;
      s1_meta_q.main     <= mainx;
      s1_meta_q.place_en <= act[other];
      s1_meta_q.use_div  <= 1'b0;
      s1_meta_q.ds       <= st[other];
      s1_src_ok_q        <= src_ok;
      s1_sts_q           <= nt[src_sel];
      s1_ss_q            <= st[src_sel];
      s1_se_q            <= ed[src_sel];
      s1_de_q            <= ed[other];
    end
  end

  // ---------------- stage 2: span differences ----------------
  logic [TW:0] off_w, dsp_w, dd_w;
  assign off_w = {1'b0, s1_sts_q} - {1'b0, s1_ss_q};
  assign dsp_w = {1'b0, s1_de_q} - {1'b0, s1_meta_q.ds};
  assign dd_w  = {1'b0, s1_se_q} - {1'b0, s1_ss_q};

  ttacs_pkg::meta_t s2_meta_q;
  ttacs_pkg::meta_t s2_meta_d;
  logic s2_valid_q;
  logic [TW:0] s2_off_q, s2_dsp_q;
  logic [TW-1:0] s2_den_q;

  // Divide only with a valid source and a positive source span.
  always_comb begin
    s2_meta_d         = s1_meta_q;
    s2_meta_d.use_div = s1_src_ok_q && !dd_w[TW] && (dd_w != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_meta_q <= s2_meta_d;
      s2_off_q  <= off_w;
      s2_dsp_q  <= dsp_w;
      s2_den_q  <= dd_w[TW-1:0];
    end
  end

  // ---------------- stage 3: offset times target span ----------------
  logic signed [2*TW+1:0] prod;
  assign prod = $signed(s2_off_q) * $signed(s2_dsp_q);

  ttacs_pkg::meta_t s3_meta_q;
  logic s3_valid_q;
  logic [2*TW+1:0] s3_prod_q;
  logic [TW-1:0] s3_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_meta_q <= s2_meta_q;
      s3_prod_q <= prod;
      s3_den_q  <= s2_den_q;
    end
  end

  // ---------------- stage 4: magnitude, overflow check ----------------
  // |prod| < 2^48; quotient of 2^26 or more saturates either way.
  logic            p_neg;
  logic [2*TW+1:0] p_abs;
  logic [2*TW-1:0] mag;
  assign p_neg = s3_prod_q[2*TW+1];
  assign p_abs = p_neg ? (~s3_prod_q + 1'b1) : s3_prod_q;
  assign mag   = p_abs[2*TW-1:0];

  ttacs_pkg::meta_t dv_meta_q [NS+1];
  logic            dv_valid_q [NS+1];
  logic [TW-1:0]   dv_r_q     [NS+1];
  logic [QB-1:0]   dv_s_q     [NS+1];
  logic [TW-1:0]   dv_den_q   [NS+1];
  logic            dv_neg_q   [NS+1];
  logic            dv_ovf_q   [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q[0] <= 1'b0;
    end else if (en) begin
      dv_valid_q[0] <= s3_valid_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_meta_q[0] <= s3_meta_q;
      dv_r_q[0]    <= {2'b00, mag[2*TW-1:QB]};
      dv_s_q[0]    <= mag[QB-1:0];
      dv_den_q[0]  <= s3_den_q;
      dv_neg_q[0]  <= p_neg;
      dv_ovf_q[0]  <= {2'b00, mag[2*TW-1:QB]} >= s3_den_q;
    end
  end

  // ---------------- divider stages ----------------
  for (genvar j = 0; j < NS; j++) begin : g_div
    logic [TW-1:0] r_n;
    logic [QB-1:0] s_n;
    logic [TW:0]   trial;
    logic          ge;
    always_comb begin
      r_n   = dv_r_q[j];
      s_n   = dv_s_q[j];
      trial = '0;
      ge    = 1'b0;
      for (int b = 0; b < ttacs_pkg::DivBitsPerStage; b++) begin
        trial = {r_n, s_n[QB-1]};
        ge    = trial >= {1'b0, dv_den_q[j]};
        r_n   = ge ? TW'(trial - {1'b0, dv_den_q[j]}) : trial[TW-1:0];
        s_n   = {s_n[QB-2:0], ge};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_valid_q[j+1] <= dv_valid_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_meta_q[j+1] <= dv_meta_q[j];
        dv_r_q[j+1]    <= r_n;
        dv_s_q[j+1]    <= s_n;
        dv_den_q[j+1]  <= dv_den_q[j];
        dv_neg_q[j+1]  <= dv_neg_q[j];
        dv_ovf_q[j+1]  <= dv_ovf_q[j];
      end
    end
  end

  // ---------------- stage 5: floor, offset, saturate, place ----------------
  ttacs_pkg::meta_t fm;
  logic [QB+1:0] qpos, qs, psum;
  logic [TW-1:0] placed;
  assign fm   = dv_meta_q[NS];
  assign qpos = {2'b00, dv_s_q[NS]};
  // Floor toward minus infinity: negate, then step down on a nonzero remainder.
  assign qs   = dv_neg_q[NS] ? ((QB+2)'(0) - qpos - {{(QB+1){1'b0}}, (dv_r_q[NS] != '0)})
                             : qpos;
  assign psum = qs + {{(QB+2-TW){1'b0}}, fm.ds};

  always_comb begin
    if (!fm.use_div) begin
      placed = fm.ds;
    end else if (dv_ovf_q[NS]) begin
      placed = dv_neg_q[NS] ? '0 : ttacs_pkg::TimeMax;
    end else if (psum[QB+1]) begin
      placed = '0;
    end else if (psum[QB:TW] != '0) begin
      placed = ttacs_pkg::TimeMax;
    end else begin
      placed = psum[TW-1:0];
    end
  end

  ttacs_pkg::meta_t s5_meta_q;
  ttacs_pkg::meta_t s5_meta_d;
  logic s5_valid_q;

  // The placed time replaces the stepped time of the non-main track.
  always_comb begin
    s5_meta_d = fm;
    if (fm.place_en && fm.main) begin
      s5_meta_d.nt0 = placed;
    end
    if (fm.place_en && !fm.main) begin
      s5_meta_d.nt1 = placed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s5_valid_q <= dv_valid_q[NS];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_meta_q <= s5_meta_d;
    end
  end

  // ---------------- stage 6: frames, output register ----------------
  logic [TW+7:0] fp0, fp1;
  assign fp0 = s5_meta_q.nt0 * s5_meta_q.rt0;
  assign fp1 = s5_meta_q.nt1 * s5_meta_q.rt1;

  logic [ttacs_pkg::OutDataW-1:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s5_valid_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {5'd0, s5_meta_q.act, s5_meta_q.main,
                s5_meta_q.act[1] ? fp1[TW+7:16] : 16'd0, s5_meta_q.nt1,
                s5_meta_q.act[0] ? fp0[TW+7:16] : 16'd0, s5_meta_q.nt0};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;

  // ---------------- checks ----------------
  `TTACS_ASSERT_ALWAYS(a_ready_tracks_out, s_tready_o == (!m_tvalid_o || m_tready_i))
  `TTACS_ASSERT_IMPL(a_frame_a_idle, m_tvalid_o && !m_tdata_o[81], m_tdata_o[39:24] == 16'd0)
  `TTACS_ASSERT_IMPL(a_frame_b_idle, m_tvalid_o && !m_tdata_o[82], m_tdata_o[79:64] == 16'd0)
  `TTACS_ASSERT_IMPL(a_no_div_no_ovf, dv_valid_q[NS] && fm.use_div && !dv_ovf_q[NS],
                     dv_r_q[NS] < dv_den_q[NS])

endmodule

FILE: bench/ttacs_checker.sv
// Checker for the animation clock sync unit: predicts each output beat and compares it.
`timescale 1ns / 1ps
module ttacs_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [ttacs_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [ttacs_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output int                             err_cnt_o,
  output int                             pending_o,
  output int                             beats_o
);

  typedef struct packed {
    logic [1:0]                   mask;
    logic                         main;
    logic [ttacs_pkg::FrameW-1:0] fr_b;
    logic [ttacs_pkg::TimeW-1:0]  nt_b;
    logic [ttacs_pkg::FrameW-1:0] fr_a;
    logic [ttacs_pkg::TimeW-1:0]  nt_a;
  } clk_out_t;

  logic [ttacs_pkg::TimeW-1:0] step_q;
  clk_out_t                    sync_q[$];

  function automatic logic [ttacs_pkg::FrameW-1:0] frame_idx(
      logic [ttacs_pkg::TimeW-1:0] t, logic [ttacs_pkg::RateW-1:0] r);
    logic [31:0] f;
    f = (32'(t) * 32'(r)) >> 16;
    return (f > 32'hFFFF) ? 16'hFFFF : f[15:0];
  endfunction

  function automatic logic [ttacs_pkg::TimeW-1:0] map_time(
      logic [ttacs_pkg::TimeW-1:0] st, logic [ttacs_pkg::TimeW-1:0] ss,
      logic [ttacs_pkg::TimeW-1:0] se, logic [ttacs_pkg::TimeW-1:0] ds,
      logic [ttacs_pkg::TimeW-1:0] de);
    longint den, num, q, r;
    den = longint'(se) - longint'(ss);
    if (den <= 0) return ds;
    num = (longint'(st) - longint'(ss)) * (longint'(de) - longint'(ds));
    q = num / den;
    r = num % den;
    if (r != 0 && num < 0) q -= 1;
    q += longint'(ds);
    if (q < 0) return '0;
    if (q > longint'(ttacs_pkg::TimeMax)) return ttacs_pkg::TimeMax;
    return q[ttacs_pkg::TimeW-1:0];
  endfunction

  function automatic clk_out_t sync_tracks(logic [ttacs_pkg::InDataW-1:0] d);
    logic [ttacs_pkg::TimeW-1:0]   tm[2], st[2], en[2], nt[2];
    logic [ttacs_pkg::RateW-1:0]   rt[2];
    logic [ttacs_pkg::WeightW-1:0] wt[2];
    logic [ttacs_pkg::FlagsW-1:0]  fl[2];
    logic [ttacs_pkg::FrameW-1:0]  fr[2];
    logic                          act[2];
    logic [24:0]                   sum;
    int                            mn, oth, src, base;
    clk_out_t                      o;
    for (int i = 0; i < 2; i++) begin
      base  = 98 * i;
      tm[i] = d[base +: 24];
      st[i] = d[base + 24 +: 24];
      en[i] = d[base + 48 +: 24];
      rt[i] = d[base + 72 +: 8];
      wt[i] = d[base + 80 +: 16];
      fl[i] = d[base + 96 +: 2];
      act[i] = !fl[i][ttacs_pkg::FlagPaused] && wt[i] != 0;
      if (act[i]) begin
        sum = 25'(tm[i]) + 25'(step_q);
        if (sum >= 25'(en[i])) nt[i] = fl[i][ttacs_pkg::FlagLoop] ? st[i] : en[i];
        else nt[i] = sum[23:0];
        fr[i] = frame_idx(nt[i], rt[i]);
      end else begin
        nt[i] = tm[i];
        fr[i] = '0;
      end
    end
    mn  = (wt[1] > wt[0]) ? 1 : 0;
    oth = 1 - mn;
    src = -1;
    if (act[mn]) src = mn;
    else if (mn == 1 && act[0]) src = 0;
    if (act[oth]) begin
      if (src < 0) nt[oth] = st[oth];
      else nt[oth] = map_time(nt[src], st[src], en[src], st[oth], en[oth]);
      fr[oth] = frame_idx(nt[oth], rt[oth]);
    end
    o.nt_a = nt[0]; o.fr_a = fr[0]; o.nt_b = nt[1]; o.fr_b = fr[1];
    o.main = mn[0];
    o.mask = {act[1], act[0]};
    return o;
  endfunction

  assign pending_o = sync_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    clk_out_t want, got;
    if (!rst_ni) begin
      step_q    <= ttacs_pkg::TimeStepReset;
      err_cnt_o <= 0;
      beats_o   <= 0;
      sync_q.delete();
    end else begin
      if (psel && penable && pwrite && paddr[2] == ttacs_pkg::RegTimeStep)
        step_q <= pwdata[ttacs_pkg::TimeW-1:0];
      if (s_tvalid_i && s_tready_i) sync_q.push_back(sync_tracks(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[$bits(clk_out_t)-1:0];
        beats_o <= beats_o + 1;
        if (sync_q.size() == 0) begin
          if (err_cnt_o < 10) $display("ERROR: unexpected output beat %h", got);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          want = sync_q.pop_front();
          if (want !== got || m_tdata_i[ttacs_pkg::OutDataW-1:$bits(clk_out_t)] !== '0) begin
            if (err_cnt_o < 10)
              $display({"ERROR: beat %0d exp nt_a=%h fr_a=%h nt_b=%h fr_b=%h main=%b",
                        " mask=%b / got nt_a=%h fr_a=%h nt_b=%h fr_b=%h main=%b mask=%b"},
                       beats_o, want.nt_a, want.fr_a, want.nt_b, want.fr_b, want.main,
                       want.mask, got.nt_a, got.fr_a, got.nt_b, got.fr_b, got.main, got.mask);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: bench/tb_two_track_animation_clock_sync_unit.sv
// Testbench top: stimulus, idling phases, register writes and the verdict.
`timescale 1ns / 1ps
module tb_two_track_animation_clock_sync_unit;

  localparam int WatchLimit = 20000;
  localparam int DrainWait  = 60;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_tvalid_i = 1'b0;
  logic                           s_tready_o;
  logic [ttacs_pkg::InDataW-1:0]  s_tdata_i = '0;
  logic                           m_tvalid_o;
  logic                           m_tready_i = 1'b0;
  logic [ttacs_pkg::OutDataW-1:0] m_tdata_o;
  logic                           psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]                     paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;
  int                             err_cnt, pending, beats;

  // idle odds in percent for each side; hold-off forces a long receiver stall
  int  send_idle = 0, recv_idle = 0;
  bit  hold_off = 1'b0;
  int  idle_cyc = 0;

  always #5 clk_i = ~clk_i;

  two_track_animation_clock_sync_unit u_dut (.*);

  ttacs_checker u_chk (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_i(s_tready_o), .s_tdata_i,
    .m_tvalid_i(m_tvalid_o), .m_tready_i, .m_tdata_i(m_tdata_o),
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .err_cnt_o(err_cnt), .pending_o(pending), .beats_o(beats)
  );

  // Receiver: random stall per cycle, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni) m_tready_i <= 1'b0;
    else m_tready_i <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  // Watchdog: cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Random span/time; mostly small spans with time near the span.
  function automatic logic [97:0] rand_track();
    logic [23:0] t, s, e;
    logic [7:0]  r;
    logic [15:0] w;
    logic [1:0]  f;
    int          k;
    k = int'($urandom_range(9));
    s = 24'($urandom_range(24'hFFFFFF));
    if (k < 6) begin
      s = 24'($urandom_range(24'h3FFFFF));
      e = s + 24'($urandom_range(24'h3FFFF));
      t = s + 24'($urandom_range(24'h3FFFF));
    end else begin
      e = 24'($urandom_range(24'hFFFFFF));
      t = 24'($urandom_range(24'hFFFFFF));
    end
    r = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(240));
    w = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(16'hFFFF));
    f = 2'($urandom_range(3));
    if ($urandom_range(2) != 0) f[ttacs_pkg::FlagPaused] = 1'b0;
    return {f, w, r, e, s, t};
  endfunction

  function automatic logic [97:0] mk_track(logic [23:0] t, logic [23:0] s, logic [23:0] e,
                                           logic [7:0] r, logic [15:0] w, logic [1:0] f);
    return {f, w, r, e, s, t};
  endfunction

  // Offer one input beat; the sender may idle first.
  task automatic push_beat(logic [97:0] ta, logic [97:0] tb);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {4'b0, tb, ta};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drain the pipe then write time_step through a setup and an access cycle.
  task automatic set_step(logic [23:0] v);
    s_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {ttacs_pkg::RegTimeStep, 2'b00};
    pwdata <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic rand_run(int n);
    for (int i = 0; i < n; i++) push_beat(rand_track(), rand_track());
    s_tvalid_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, ties, pause, loop/clamp, empty and reversed spans.
    push_beat(mk_track(24'd0, 24'd0, 24'hFFFFFF, 8'd240, 16'hFFFF, 2'b00),
              mk_track(24'd0, 24'd0, 24'hFFFFFF, 8'd240, 16'hFFFF, 2'b00));
    push_beat(mk_track(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 16'd1, 2'b10),
              mk_track(24'hFFFFFF, 24'd0, 24'hFFFFFF, 8'hFF, 16'd2, 2'b10));
    push_beat(mk_track(24'd100, 24'd0, 24'd500, 8'd30, 16'd0, 2'b00),
              mk_track(24'd100, 24'd0, 24'd500, 8'd30, 16'd5, 2'b00));
    push_beat(mk_track(24'd100, 24'd0, 24'd500, 8'd30, 16'd9, 2'b01),
              mk_track(24'd100, 24'd50, 24'd900, 8'd60, 16'd5, 2'b00));
    push_beat(mk_track(24'd100, 24'd0, 24'd5000, 8'd24, 16'd3, 2'b01),
              mk_track(24'd7, 24'd1000, 24'd9000, 8'd60, 16'd9, 2'b00));
    push_beat(mk_track(24'd100, 24'd0, 24'd5000, 8'd24, 16'd3, 2'b00),
              mk_track(24'd7, 24'd1000, 24'd9000, 8'd60, 16'd9, 2'b11));
    push_beat(mk_track(24'd4000, 24'd500, 24'd4500, 8'd24, 16'd7, 2'b10),
              mk_track(24'd7, 24'd100, 24'd900, 8'd60, 16'd1, 2'b00));
    push_beat(mk_track(24'd4000, 24'd500, 24'd4500, 8'd24, 16'd7, 2'b00),
              mk_track(24'd7, 24'd100, 24'd900, 8'd60, 16'd1, 2'b00));
    push_beat(mk_track(24'd10, 24'd900, 24'd900, 8'd24, 16'd7, 2'b00),
              mk_track(24'd7, 24'd100, 24'd900, 8'd60, 16'd1, 2'b00));
    push_beat(mk_track(24'd10, 24'd9000, 24'd900, 8'd24, 16'd7, 2'b00),
              mk_track(24'd7, 24'd100, 24'd900, 8'd60, 16'd1, 2'b00));
    push_beat(mk_track(24'd10, 24'd90000, 24'd100000, 8'd24, 16'd7, 2'b00),
              mk_track(24'd7, 24'd100, 24'hFFFFF0, 8'd60, 16'd1, 2'b00));
    push_beat(mk_track(24'd10, 24'd90000, 24'd90010, 8'd24, 16'd7, 2'b00),
              mk_track(24'd7, 24'hFFFFF0, 24'd100, 8'd60, 16'd1, 2'b00));
    push_beat(mk_track(24'd999000, 24'd0, 24'hFFFFFF, 8'd240, 16'h8000, 2'b00),
              mk_track(24'd7, 24'd0, 24'hFFFFFF, 8'd255, 16'h7FFF, 2'b00));
    s_tvalid_i <= 1'b0;

    set_step(24'd0);
    rand_run(60);
    set_step(24'hFFFFFF);
    rand_run(60);
    set_step(24'($urandom_range(24'hFFFF)));

    send_idle = 88; recv_idle = 0;  rand_run(60);
    send_idle = 0;  recv_idle = 88; rand_run(60);
    send_idle = 35; recv_idle = 35; rand_run(60);

    // Long receiver hold-off while the sender keeps offering beats.
    send_idle = 0; recv_idle = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      rand_run(80);
    join
    set_step(ttacs_pkg::TimeStepReset);
    recv_idle = 20; rand_run(70);

    while (pending != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    $display("Run covered %0d output beats over time_step 0, max, random and reset,", beats);
    $display("with directed span/weight corners, idle and stall phases and a long hold-off.");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: two_track_animation_clock_sync_unit.f
+incdir+src
src/ttacs_pkg.sv
src/two_track_animation_clock_sync_unit.sv
bench/ttacs_checker.sv
bench/tb_two_track_animation_clock_sync_unit.sv
